// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared definitions for the rotation matrix to quaternion core
// Holds the fixed field widths, the default fraction width and the codes
// for the component that is taken from the square root.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Width of every matrix entry and quaternion component.
    localparam int DATA_W = 16;

    // Default number of fraction bits (Q2.14).
    localparam int DEF_FRAC_BITS = 14;

    // Quotient width of the scaling divisions; the quotient never exceeds 2^15 + 1.
    localparam int QUOT_W = 17;

    // Width of a sum or difference of two entries.
    localparam int PAIR_W = DATA_W + 1;

    // Number of divided components.
    localparam int LANES = 3;

    typedef logic [1:0] comp_t;

    // Component taken from the square root.
    localparam comp_t COMP_W = 2'd0;
    localparam comp_t COMP_X = 2'd1;
    localparam comp_t COMP_Y = 2'd2;
    localparam comp_t COMP_Z = 2'd3;

endpackage

// ===== rtl/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one bit of a pipelined integer square root
// Tries one root bit against the remaining radicand and registers the new
// remainder, the partial root and the side data for the next cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int REM_W  = 34,
    parameter int ROOT_W = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SIDE_W-1:0] side_reg;

    // (2r + b) * b with b = 2^BIT, where r holds only higher bits.
    always_comb
    begin
        trial     = (REM_W'(root_in) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
        take      = (rem_in >= trial);
        rem_next  = take ? (rem_in - trial) : rem_in;
        root_next = take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ===== rtl/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit of three parallel restoring divisions
// Subtracts the shifted divisor from each lane's remainder where it fits and
// registers remainders, quotients, divisor and side data for the next cell.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 18,
    parameter int BIT    = 0,
    parameter int SIDE_W = 8
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [rmq_pkg::LANES-1:0][NUM_W-1:0]       rem_in,
    input  logic [rmq_pkg::LANES-1:0][rmq_pkg::QUOT_W-1:0] quot_in,
    input  logic [DEN_W-1:0]                           den_in,
    input  logic [SIDE_W-1:0]                          side_in,
    output logic [rmq_pkg::LANES-1:0][NUM_W-1:0]       rem_out,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUOT_W-1:0] quot_out,
    output logic [DEN_W-1:0]                           den_out,
    output logic [SIDE_W-1:0]                          side_out
);

    localparam int CMP_W = NUM_W + DEN_W + rmq_pkg::QUOT_W;

    logic [CMP_W-1:0]                              shifted;
    logic [rmq_pkg::LANES-1:0][NUM_W-1:0]          rem_next;
    logic [rmq_pkg::LANES-1:0][rmq_pkg::QUOT_W-1:0] quot_next;
    logic [rmq_pkg::LANES-1:0][NUM_W-1:0]          rem_reg;
    logic [rmq_pkg::LANES-1:0][rmq_pkg::QUOT_W-1:0] quot_reg;
    logic [DEN_W-1:0]                              den_reg;
    logic [SIDE_W-1:0]                             side_reg;

    // Compare and subtract in every lane against the divisor shifted to this bit.
    always_comb
    begin
        shifted = CMP_W'(den_in) << BIT;
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            if (CMP_W'(rem_in[l]) >= shifted)
            begin
                rem_next[l]  = rem_in[l] - shifted[NUM_W-1:0];
                quot_next[l] = quot_in[l] | (rmq_pkg::QUOT_W'(1) << BIT);
            end
            else
            begin
                rem_next[l]  = rem_in[l];
                quot_next[l] = quot_in[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign quot_out = quot_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;

endmodule

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core: Shepperd rotation matrix to quaternion
// Fixed-point conversion of a 3x3 rotation matrix into a quaternion.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, m00..m22) carries one matrix per
// transaction; the output channel (out_valid, out_stall, qx..qw,
// largest_comp) carries one quaternion per transaction.
// The block is a row of cells: an entry stage picks the largest diagonal
// candidate, one square root cell per root bit follows, then a scaling stage,
// then seventeen divider cells (one quotient bit each, three lanes), then the
// output register. HW is the root width, 15 bits at 14 fraction bits.
// Throughput is one matrix per cycle while no result is held; every cell moves
// its data on each cycle that the row is not held.
// When the receiver stalls a waiting result, the whole row holds and in_stall
// rises in the same cycle; empty slots still fill while the output is free.
// Reset clears all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::DEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0] m00,
    input  logic signed [rmq_pkg::DATA_W-1:0] m01,
    input  logic signed [rmq_pkg::DATA_W-1:0] m02,
    input  logic signed [rmq_pkg::DATA_W-1:0] m10,
    input  logic signed [rmq_pkg::DATA_W-1:0] m11,
    input  logic signed [rmq_pkg::DATA_W-1:0] m12,
    input  logic signed [rmq_pkg::DATA_W-1:0] m20,
    input  logic signed [rmq_pkg::DATA_W-1:0] m21,
    input  logic signed [rmq_pkg::DATA_W-1:0] m22,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [rmq_pkg::DATA_W-1:0] qx,
    output logic signed [rmq_pkg::DATA_W-1:0] qy,
    output logic signed [rmq_pkg::DATA_W-1:0] qz,
    output logic signed [rmq_pkg::DATA_W-1:0] qw,
    output logic [1:0]                 largest_comp
);

    localparam int DW     = rmq_pkg::DATA_W;
    localparam int PW     = rmq_pkg::PAIR_W;
    localparam int QW     = rmq_pkg::QUOT_W;
    localparam int LN     = rmq_pkg::LANES;
    localparam int CAND_W = DW + 2;
    localparam int SUM_W  = ((CAND_W - 1 > FRAC_BITS) ? (CAND_W - 1) : FRAC_BITS) + 1;
    localparam int RAD_W  = SUM_W + FRAC_BITS - 2;
    localparam int HW     = (RAD_W + 1) / 2;
    localparam int REM_W  = 2 * HW + 2;
    localparam int DEN_W  = HW + 2;
    localparam int NUM_W  = (((PW + FRAC_BITS) > (HW + 1)) ? (PW + FRAC_BITS) : (HW + 1)) + 1;
    localparam int SQ_SIDE_W  = 2 + LN * PW;
    localparam int DIV_SIDE_W = 2 + LN + HW;
    localparam int STAGES = HW + QW + 3;
    localparam logic [QW-1:0] POS_MAX = QW'(32767);
    localparam logic [QW-1:0] NEG_MAX = QW'(32768);

    logic en;
    logic [STAGES-1:0] vld_reg;

    // The row advances unless a finished result is held by the receiver.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Valid flags travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[STAGES-1];

    // Entry stage: candidates, selection and the three off-diagonal pairs.
    logic signed [CAND_W-1:0] c0, c1, c2, c3, best;
    rmq_pkg::comp_t           sel;
    logic signed [PW-1:0]     p12m, p20m, p01m, p01p, p20p, p12p;
    logic [LN-1:0][PW-1:0]    pair_next;
    logic [SUM_W-1:0]         sum1;
    logic [RAD_W-1:0]         rad_next;
    logic [RAD_W-1:0]         rad_reg;
    logic [LN-1:0][PW-1:0]    pair_reg;
    rmq_pkg::comp_t           sel_reg;

    always_comb
    begin
        c0 = CAND_W'(m00) + CAND_W'(m11) + CAND_W'(m22);
        c1 = CAND_W'(m00) - CAND_W'(m11) - CAND_W'(m22);
        c2 = -CAND_W'(m00) + CAND_W'(m11) - CAND_W'(m22);
        c3 = -CAND_W'(m00) - CAND_W'(m11) + CAND_W'(m22);
        best = c0;
        sel  = rmq_pkg::COMP_W;
        if (c1 > best)
        begin
            best = c1;
            sel  = rmq_pkg::COMP_X;
        end
        if (c2 > best)
        begin
            best = c2;
            sel  = rmq_pkg::COMP_Y;
        end
        if (c3 > best)
        begin
            best = c3;
            sel  = rmq_pkg::COMP_Z;
        end
        // The largest candidate is never negative.
        sum1     = SUM_W'(best[CAND_W-2:0]) + (SUM_W'(1) << FRAC_BITS);
        rad_next = RAD_W'(sum1) << (FRAC_BITS - 2);
        p12m = PW'(m12) - PW'(m21);
        p20m = PW'(m20) - PW'(m02);
        p01m = PW'(m01) - PW'(m10);
        p01p = PW'(m01) + PW'(m10);
        p20p = PW'(m20) + PW'(m02);
        p12p = PW'(m12) + PW'(m21);
        // Pairs for the three divided components, in x, y, z, w order.
        unique case (sel)
            rmq_pkg::COMP_W: pair_next = {p01m, p20m, p12m};
            rmq_pkg::COMP_X: pair_next = {p12m, p20p, p01p};
            rmq_pkg::COMP_Y: pair_next = {p20m, p12p, p01p};
            default:         pair_next = {p01m, p12p, p20p};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            pair_reg <= pair_next;
            sel_reg  <= sel;
        end
    end

    // Square root chain, one root bit per cell.
    logic [REM_W-1:0]     sq_rem  [0:HW];
    logic [HW-1:0]        sq_root [0:HW];
    logic [SQ_SIDE_W-1:0] sq_side [0:HW];

    assign sq_rem[0]  = REM_W'(rad_reg);
    assign sq_root[0] = '0;
    assign sq_side[0] = {sel_reg, pair_reg};

    for (genvar i = 0; i < HW; i++)
    begin : g_sqrt
        rmq_sqrt_cell #(
            .REM_W  (REM_W),
            .ROOT_W (HW),
            .BIT    (HW - 1 - i),
            .SIDE_W (SQ_SIDE_W)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    // Scaling stage: magnitudes shifted up, rounding offset and divisor 4h.
    logic [HW-1:0]              h_s;
    rmq_pkg::comp_t             sel_s;
    logic [LN-1:0][PW-1:0]      pair_s;
    logic [LN-1:0][PW-1:0]      mag_s;
    logic [LN-1:0][NUM_W-1:0]   num_next;
    logic [LN-1:0]              neg_next;
    logic [LN-1:0][NUM_W-1:0]   num_reg;
    logic [LN-1:0]              neg_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [HW-1:0]              h_reg;
    rmq_pkg::comp_t             sel2_reg;

    always_comb
    begin
        h_s    = sq_root[HW];
        sel_s  = sq_side[HW][SQ_SIDE_W-1 -: 2];
        pair_s = sq_side[HW][LN*PW-1:0];
        for (int l = 0; l < LN; l++)
        begin
            neg_next[l] = pair_s[l][PW-1];
            // The magnitude is taken at pair width; the most negative pair still fits.
            mag_s[l]    = neg_next[l] ? (PW'(0) - pair_s[l]) : pair_s[l];
            num_next[l] = (NUM_W'(mag_s[l]) << FRAC_BITS) + (NUM_W'(h_s) << 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            neg_reg  <= neg_next;
            den_reg  <= DEN_W'(h_s) << 2;
            h_reg    <= h_s;
            sel2_reg <= sel_s;
        end
    end

    // Divider chain, one quotient bit per cell in all three lanes.
    logic [LN-1:0][NUM_W-1:0] dv_rem  [0:QW];
    logic [LN-1:0][QW-1:0]    dv_quot [0:QW];
    logic [DEN_W-1:0]         dv_den  [0:QW];
    logic [DIV_SIDE_W-1:0]    dv_side [0:QW];

    assign dv_rem[0]  = num_reg;
    assign dv_quot[0] = '0;
    assign dv_den[0]  = den_reg;
    assign dv_side[0] = {sel2_reg, neg_reg, h_reg};

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        rmq_div_cell #(
            .NUM_W  (NUM_W),
            .DEN_W  (DEN_W),
            .BIT    (QW - 1 - i),
            .SIDE_W (DIV_SIDE_W)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (dv_rem[i]),
            .quot_in  (dv_quot[i]),
            .den_in   (dv_den[i]),
            .side_in  (dv_side[i]),
            .rem_out  (dv_rem[i+1]),
            .quot_out (dv_quot[i+1]),
            .den_out  (dv_den[i+1]),
            .side_out (dv_side[i+1])
        );
    end

    // Output stage: sign, saturation and placement of the four components.
    logic [HW-1:0]         h_f;
    logic [LN-1:0]         neg_f;
    rmq_pkg::comp_t        sel_f;
    logic [LN-1:0][DW-1:0] res;
    logic [DW-1:0]         hv;
    logic [DW-1:0]         qx_next, qy_next, qz_next, qw_next;
    logic [DW-1:0]         qx_reg, qy_reg, qz_reg, qw_reg;
    rmq_pkg::comp_t        comp_reg;

    always_comb
    begin
        h_f   = dv_side[QW][HW-1:0];
        neg_f = dv_side[QW][HW +: LN];
        sel_f = dv_side[QW][DIV_SIDE_W-1 -: 2];
        hv    = (h_f > HW'(32767)) ? DW'(32767) : DW'(h_f);
        for (int l = 0; l < LN; l++)
        begin
            if (neg_f[l])
            begin
                res[l] = (dv_quot[QW][l] > NEG_MAX) ? DW'(32768) : DW'(-dv_quot[QW][l]);
            end
            else
            begin
                res[l] = (dv_quot[QW][l] > POS_MAX) ? DW'(32767) : DW'(dv_quot[QW][l]);
            end
        end
        unique case (sel_f)
            rmq_pkg::COMP_W:
            begin
                qx_next = res[0]; qy_next = res[1]; qz_next = res[2]; qw_next = hv;
            end
            rmq_pkg::COMP_X:
            begin
                qx_next = hv; qy_next = res[0]; qz_next = res[1]; qw_next = res[2];
            end
            rmq_pkg::COMP_Y:
            begin
                qx_next = res[0]; qy_next = hv; qz_next = res[1]; qw_next = res[2];
            end
            default:
            begin
                qx_next = res[0]; qy_next = res[1]; qz_next = hv; qw_next = res[2];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            qz_reg   <= qz_next;
            qw_reg   <= qw_next;
            comp_reg <= sel_f;
        end
    end

    assign qx           = qx_reg;
    assign qy           = qy_reg;
    assign qz           = qz_reg;
    assign qw           = qw_reg;
    assign largest_comp = comp_reg;

    // The root component is at least one half, so it is always positive.
    a_root_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((largest_comp == rmq_pkg::COMP_W) && (qw > 0)) ||
            ((largest_comp == rmq_pkg::COMP_X) && (qx > 0)) ||
            ((largest_comp == rmq_pkg::COMP_Y) && (qy > 0)) ||
            ((largest_comp == rmq_pkg::COMP_Z) && (qz > 0)))
        else $error("root component not positive");

    // Input back-pressure follows only a held result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stalled without a held result");

    // An accepted transaction occupies the entry stage on the next cycle.
    a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted transaction lost at entry");

    // A held result keeps the whole row frozen.
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved during a held result");

endmodule
